@@ rtl/core/picr_pkg.sv @@
// types, codes and microcode table of the pi regulator sequencer
`default_nettype none

package picr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned UREG_W = 31;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned WIDE_W = 49;

    localparam logic [UREG_W-1:0]        KP_RESET      = 31'd65536;
    localparam logic [UREG_W-1:0]        INV_TI_RESET  = 31'd65536;
    localparam logic [UREG_W-1:0]        HALF_TS_RESET = 31'd32768;
    localparam logic [UREG_W-1:0]        ILIMIT_RESET  = 31'd6553600;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 32'sd0;
    localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 32'sd6553600;
    localparam logic [UREG_W-1:0]        STEP_RESET    = 31'd16384;

    typedef enum logic [2:0] {
        CFG_GAIN_KP        = 3'd0,
        CFG_INV_TI         = 3'd1,
        CFG_HALF_TS        = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUT_MIN        = 3'd4,
        CFG_OUT_MAX        = 3'd5,
        CFG_STEP_LIMIT     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [UREG_W-1:0]        gain_kp;
        logic [UREG_W-1:0]        inv_ti;
        logic [UREG_W-1:0]        half_ts;
        logic [UREG_W-1:0]        integral_limit;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic [UREG_W-1:0]        step_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        STAT_NONE = 2'd0,
        STAT_MIN  = 2'd1,
        STAT_MAX  = 2'd2
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'd0,
        ST_ERR   = 4'd1,
        ST_MUL_I = 4'd2,
        ST_INTEG = 4'd3,
        ST_MUL_P = 4'd4,
        ST_INNER = 4'd5,
        ST_MUL_D = 4'd6,
        ST_OUT   = 4'd7,
        ST_RAMP  = 4'd8
    } step_t;

    typedef enum logic [2:0] {
        UOP_NOP   = 3'd0,
        UOP_LOAD  = 3'd1,
        UOP_ERR   = 3'd2,
        UOP_MUL   = 3'd3,
        UOP_INTEG = 3'd4,
        UOP_INNER = 3'd5,
        UOP_OUT   = 3'd6,
        UOP_RAMP  = 3'd7
    } uop_t;

    typedef enum logic [1:0] {
        MUL_TRAP  = 2'd0,
        MUL_INT   = 2'd1,
        MUL_DRIVE = 2'd2
    } mul_sel_t;

    typedef enum logic [2:0] {
        COND_NEVER    = 3'd0,
        COND_ALWAYS   = 3'd1,
        COND_ACCEPT   = 3'd2,
        COND_RAMP     = 3'd3,
        COND_OUT_FREE = 3'd4
    } cond_t;

    typedef struct packed {
        uop_t     uop;
        mul_sel_t mul_sel;
        cond_t    cond;
        logic     hold;
        step_t    target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic op_ramp;
        logic out_free;
    } flags_t;

    function automatic ctrl_t picr_ucode(input step_t step);
        ctrl_t w;
        w = '{uop: UOP_NOP, mul_sel: MUL_TRAP, cond: COND_NEVER, hold: 1'b0,
              target: ST_IDLE};
        case (step)
            ST_IDLE:
            begin
                w.uop    = UOP_LOAD;
                w.cond   = COND_ACCEPT;
                w.hold   = 1'b1;
                w.target = ST_ERR;
            end
            ST_ERR:
            begin
                w.uop    = UOP_ERR;
                w.cond   = COND_RAMP;
                w.target = ST_RAMP;
            end
            ST_MUL_I:
            begin
                w.uop     = UOP_MUL;
                w.mul_sel = MUL_TRAP;
            end
            ST_INTEG:
            begin
                w.uop = UOP_INTEG;
            end
            ST_MUL_P:
            begin
                w.uop     = UOP_MUL;
                w.mul_sel = MUL_INT;
            end
            ST_INNER:
            begin
                w.uop = UOP_INNER;
            end
            ST_MUL_D:
            begin
                w.uop     = UOP_MUL;
                w.mul_sel = MUL_DRIVE;
            end
            ST_OUT:
            begin
                w.uop    = UOP_OUT;
                w.cond   = COND_OUT_FREE;
                w.hold   = 1'b1;
                w.target = ST_IDLE;
            end
            ST_RAMP:
            begin
                w.uop    = UOP_RAMP;
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (x > hi)
        begin
            return hi[DATA_W-1:0];
        end
        else if (x < lo)
        begin
            return lo[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/picr_cfg.sv @@
// configuration register bank
`default_nettype none

module picr_cfg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_addr,
    input  wire logic [31:0]           cfg_data,
    output picr_pkg::cfg_t             cfg
);
    import picr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_GAIN_KP:        cfg_next.gain_kp        = cfg_data[UREG_W-1:0];
                CFG_INV_TI:         cfg_next.inv_ti         = cfg_data[UREG_W-1:0];
                CFG_HALF_TS:        cfg_next.half_ts        = cfg_data[UREG_W-1:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[UREG_W-1:0];
                CFG_OUT_MIN:        cfg_next.out_min        = $signed(cfg_data);
                CFG_OUT_MAX:        cfg_next.out_max        = $signed(cfg_data);
                CFG_STEP_LIMIT:     cfg_next.step_limit     = cfg_data[UREG_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_kp        <= KP_RESET;
            cfg_reg.inv_ti         <= INV_TI_RESET;
            cfg_reg.half_ts        <= HALF_TS_RESET;
            cfg_reg.integral_limit <= ILIMIT_RESET;
            cfg_reg.out_min        <= OUT_MIN_RESET;
            cfg_reg.out_max        <= OUT_MAX_RESET;
            cfg_reg.step_limit     <= STEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/core/picr_seq.sv @@
// microcode sequencer: step counter, jump logic and control word table
`default_nettype none

module picr_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire picr_pkg::flags_t flags,
    output picr_pkg::ctrl_t       ctrl
);
    import picr_pkg::*;

    step_t pc_reg;
    step_t pc_next;
    ctrl_t word;
    logic  taken;

    // control word output
    always_comb
    begin
        word = picr_ucode(pc_reg);
    end

    // next step
    always_comb
    begin
        case (word.cond)
            COND_NEVER:    taken = 1'b0;
            COND_ALWAYS:   taken = 1'b1;
            COND_ACCEPT:   taken = flags.accept;
            COND_RAMP:     taken = flags.op_ramp;
            COND_OUT_FREE: taken = flags.out_free;
            default:       taken = 1'b1;
        endcase
        if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = step_t'(pc_reg + 4'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl = word;

endmodule

`default_nettype wire

@@ rtl/core/picr_dp.sv @@
// datapath: shared multiplier, clamps, controller state and output register
`default_nettype none

module picr_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire picr_pkg::ctrl_t ctrl,
    input  wire picr_pkg::cfg_t  cfg,
    output picr_pkg::flags_t     flags,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [63:0]     s_tdata,
    input  wire logic [0:0]      s_tuser,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic [1:0]           m_tuser
);
    import picr_pkg::*;

    logic                       op_reg;
    logic signed [DATA_W-1:0]   meas_reg;
    logic signed [DATA_W-1:0]   tgt_reg;
    logic signed [DATA_W-1:0]   err_reg;
    logic [UREG_W-1:0]          integ_reg;
    logic signed [DATA_W-1:0]   inner_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DATA_W-1:0]   drive_reg;
    stat_t                      stat_reg;

    logic                       op_next;
    logic signed [DATA_W-1:0]   meas_next;
    logic signed [DATA_W-1:0]   tgt_next;
    logic signed [DATA_W-1:0]   err_next;
    logic [UREG_W-1:0]          integ_next;
    logic signed [DATA_W-1:0]   inner_next;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [DATA_W-1:0]   drive_next;
    stat_t                      stat_next;

    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   prev_err_reg;
    logic [UREG_W-1:0]          prev_int_reg;
    logic signed [DATA_W-1:0]   sp_reg;
    logic                       out_valid_next;
    logic signed [DATA_W-1:0]   prev_err_next;
    logic [UREG_W-1:0]          prev_int_next;
    logic signed [DATA_W-1:0]   sp_next;

    logic                       accept;
    logic                       out_free;
    logic signed [DATA_W:0]     mul_a;
    logic signed [DATA_W:0]     mul_b;
    logic signed [2*DATA_W+1:0] mul_full;
    logic signed [DATA_W:0]     err_diff;
    logic signed [PROD_W-FRAC_W-1:0] prod_sh;
    logic signed [WIDE_W-1:0]   integ_sum;
    logic signed [WIDE_W-1:0]   inner_sum;
    logic signed [PROD_W-FRAC_W-1:0] drv_min;
    logic signed [PROD_W-FRAC_W-1:0] drv_max;
    logic signed [DATA_W-1:0]   drv_clamped;
    logic signed [DATA_W:0]     ramp_delta;

    assign s_tready = (ctrl.uop == UOP_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign flags    = '{accept: accept, op_ramp: op_reg, out_free: out_free};

    // shared multiplier operands
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_TRAP:
            begin
                mul_a = $signed({2'b00, cfg.half_ts});
                mul_b = {err_reg[DATA_W-1], err_reg} + {prev_err_reg[DATA_W-1], prev_err_reg};
            end
            MUL_INT:
            begin
                mul_a = $signed({2'b00, cfg.inv_ti});
                mul_b = $signed({2'b00, integ_reg});
            end
            MUL_DRIVE:
            begin
                mul_a = $signed({2'b00, cfg.gain_kp});
                mul_b = {inner_reg[DATA_W-1], inner_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full   = mul_a * mul_b;
    assign prod_sh    = prod_reg[PROD_W-1:FRAC_W];
    assign err_diff   = {sp_reg[DATA_W-1], sp_reg} - {meas_reg[DATA_W-1], meas_reg};
    assign integ_sum  = WIDE_W'(prod_sh) + $signed({18'd0, prev_int_reg});
    assign inner_sum  = WIDE_W'(prod_sh) + WIDE_W'(err_reg);
    assign drv_min    = (PROD_W-FRAC_W)'(cfg.out_min);
    assign drv_max    = (PROD_W-FRAC_W)'(cfg.out_max);
    assign ramp_delta = {tgt_reg[DATA_W-1], tgt_reg} - {sp_reg[DATA_W-1], sp_reg};

    // inverted bounds: raise to minimum first
    always_comb
    begin
        if (prod_sh < drv_min)
        begin
            drv_clamped = cfg.out_min;
        end
        else if (prod_sh > drv_max)
        begin
            drv_clamped = cfg.out_max;
        end
        else
        begin
            drv_clamped = prod_sh[DATA_W-1:0];
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        meas_next      = meas_reg;
        tgt_next       = tgt_reg;
        err_next       = err_reg;
        integ_next     = integ_reg;
        inner_next     = inner_reg;
        prod_next      = prod_reg;
        drive_next     = drive_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        prev_err_next  = prev_err_reg;
        prev_int_next  = prev_int_reg;
        sp_next        = sp_reg;
        case (ctrl.uop)
            UOP_LOAD:
            begin
                if (accept)
                begin
                    op_next   = s_tuser[0];
                    meas_next = $signed(s_tdata[31:0]);
                    tgt_next  = $signed(s_tdata[63:32]);
                end
            end
            UOP_ERR:
            begin
                err_next = sat32(WIDE_W'(err_diff));
            end
            UOP_MUL:
            begin
                prod_next = mul_full[PROD_W-1:0];
            end
            UOP_INTEG:
            begin
                if (integ_sum > $signed({18'd0, cfg.integral_limit}))
                begin
                    integ_next = cfg.integral_limit;
                end
                else if (integ_sum < 0)
                begin
                    integ_next = '0;
                end
                else
                begin
                    integ_next = integ_sum[UREG_W-1:0];
                end
            end
            UOP_INNER:
            begin
                inner_next = sat32(inner_sum);
            end
            UOP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = drv_clamped;
                    if (drv_clamped == cfg.out_min)
                    begin
                        stat_next = STAT_MIN;
                    end
                    else if (drv_clamped == cfg.out_max)
                    begin
                        stat_next = STAT_MAX;
                    end
                    else
                    begin
                        stat_next = STAT_NONE;
                    end
                    prev_err_next = err_reg;
                    prev_int_next = integ_reg;
                end
            end
            UOP_RAMP:
            begin
                if (ramp_delta > $signed({2'b00, cfg.step_limit}))
                begin
                    sp_next = sp_reg + $signed({1'b0, cfg.step_limit});
                end
                else
                begin
                    sp_next = tgt_reg;
                end
            end
            default:
            begin
                sp_next = sp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            prev_int_reg  <= '0;
            sp_reg        <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            prev_err_reg  <= prev_err_next;
            prev_int_reg  <= prev_int_next;
            sp_reg        <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        meas_reg  <= meas_next;
        tgt_reg   <= tgt_next;
        err_reg   <= err_next;
        integ_reg <= integ_next;
        inner_reg <= inner_next;
        prod_reg  <= prod_next;
        drive_reg <= drive_next;
        stat_reg  <= stat_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drive_reg;
    assign m_tuser  = stat_reg;

endmodule

`default_nettype wire

@@ rtl/core/pi_controller_antiwindup_ratelimit.sv @@
// top level of the pi regulator with anti-windup and setpoint ramp
`default_nettype none

// PI regulator in signed Q16.16 driven by a small microcode sequencer over one
// shared 33x33 multiplier. A control sample (tuser 0) runs the error, trapezoid
// product, integral clamp, integral product, inner sum, drive product and output
// steps with three multiplications in sequence and returns one item; a held
// output stalls it in the output step, and the next item is taken back in idle.
// A setpoint ramp step (tuser 1) returns nothing. Configuration is written with
// cfg_we, cfg_addr and cfg_data while no item is in flight.
module pi_controller_antiwindup_ratelimit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // measured [31:0], target_setpoint [63:32]
    input  wire logic [0:0]  s_tuser,   // op [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // drive [31:0]
    output logic [1:0]       m_tuser,   // limit_status [1:0]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_data
);
    import picr_pkg::*;

    cfg_t   cfg;
    ctrl_t  ctrl;
    flags_t flags;

    picr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    picr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    picr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cfg      (cfg),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    // one item at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while sequencer busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad limit status");

    a_status_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_MIN |-> $signed(m_tdata) == cfg.out_min)
        else $error("status min without drive at minimum");

    a_drive_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cfg.out_min <= cfg.out_max
        |-> $signed(m_tdata) >= cfg.out_min && $signed(m_tdata) <= cfg.out_max)
        else $error("drive outside bounds");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the pi regulator with anti-windup and setpoint ramp
`timescale 1ns / 1ps

module testbench;
    import picr_pkg::*;

    typedef struct packed {
        logic [31:0] drive;
        stat_t       status;
    } drive_result_t;

    typedef struct packed {
        logic               op;
        logic signed [31:0] measured;
        logic signed [31:0] target;
        logic               typed;
        logic [31:0]        drive;
        stat_t              status;
    } directed_row_t;

    typedef enum int {
        MODE_NOMINAL,
        MODE_MAX,
        MODE_ZERO,
        MODE_INVERTED,
        MODE_FULL
    } cfg_mode_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_RAMP   = 1'b1;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam int N_DIRECTED = 16;
    localparam int N_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 200;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_data;

    pi_controller_antiwindup_ratelimit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // regulator state and registers as the predictor sees them
    longint kp_q;
    longint inv_ti_q;
    longint half_ts_q;
    longint ilimit_q;
    longint out_min_q;
    longint out_max_q;
    longint step_q;
    longint err_prev;
    longint integ_prev;
    longint setpoint;

    drive_result_t expected_drives[$];
    directed_row_t directed_rows[N_DIRECTED];
    cfg_mode_t     phase_modes[N_PHASES];

    int fail_count = 0;
    int n_samples = 0;
    int n_ramps = 0;
    int n_results = 0;
    int n_configs = 0;
    int burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    function automatic longint clip32(input longint x);
        if (x > longint'(S32_MAX))
        begin
            return longint'(S32_MAX);
        end
        if (x < longint'(S32_MIN))
        begin
            return longint'(S32_MIN);
        end
        return x;
    endfunction

    function automatic void ramp_setpoint(input logic signed [31:0] tgt);
        longint t;
        t = longint'(tgt);
        if (t - setpoint > step_q)
        begin
            setpoint = setpoint + step_q;
        end
        else
        begin
            setpoint = t;
        end
    endfunction

    function automatic drive_result_t regulate_sample(input logic signed [31:0] meas);
        longint err;
        longint integ;
        longint inner;
        longint drv;
        drive_result_t r;
        err = clip32(setpoint - longint'(meas));
        integ = ((half_ts_q * (err + err_prev)) >>> 16) + integ_prev;
        if (integ > ilimit_q)
        begin
            integ = ilimit_q;
        end
        else if (integ < 0)
        begin
            integ = 0;
        end
        inner = clip32(err + ((inv_ti_q * integ) >>> 16));
        drv = (kp_q * inner) >>> 16;
        if (drv < out_min_q)
        begin
            drv = out_min_q;
        end
        else if (drv > out_max_q)
        begin
            drv = out_max_q;
        end
        if (drv == out_min_q)
        begin
            r.status = STAT_MIN;
        end
        else if (drv == out_max_q)
        begin
            r.status = STAT_MAX;
        end
        else
        begin
            r.status = STAT_NONE;
        end
        r.drive = drv[31:0];
        err_prev = err;
        integ_prev = integ;
        return r;
    endfunction

    task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            CFG_GAIN_KP:        kp_q = longint'(val[30:0]);
            CFG_INV_TI:         inv_ti_q = longint'(val[30:0]);
            CFG_HALF_TS:        half_ts_q = longint'(val[30:0]);
            CFG_INTEGRAL_LIMIT: ilimit_q = longint'(val[30:0]);
            CFG_OUT_MIN:        out_min_q = longint'($signed(val));
            CFG_OUT_MAX:        out_max_q = longint'($signed(val));
            CFG_STEP_LIMIT:     step_q = longint'(val[30:0]);
            default:            ;
        endcase
    endtask

    task automatic load_config(input cfg_mode_t mode);
        logic [31:0] kp;
        logic [31:0] iti;
        logic [31:0] hts;
        logic [31:0] ilim;
        logic [31:0] omin;
        logic [31:0] omax;
        logic [31:0] stp;
        // bit 31 of the unsigned registers is noise the block drops
        kp   = $urandom_range(0, 262144)  | {1'($urandom_range(0, 1)), 31'b0};
        iti  = $urandom_range(0, 131072)  | {1'($urandom_range(0, 1)), 31'b0};
        hts  = $urandom_range(0, 65536)   | {1'($urandom_range(0, 1)), 31'b0};
        ilim = $urandom_range(0, 1 << 24) | {1'($urandom_range(0, 1)), 31'b0};
        omin = -$urandom_range(0, 1 << 24);
        omax = $urandom_range(0, 1 << 24);
        stp  = $urandom_range(0, 1 << 20) | {1'($urandom_range(0, 1)), 31'b0};
        case (mode)
            MODE_MAX:
            begin
                kp   = 32'hFFFFFFFF;
                iti  = 32'hFFFFFFFF;
                hts  = 32'hFFFFFFFF;
                ilim = 32'hFFFFFFFF;
                omin = S32_MIN;
                omax = S32_MAX;
                stp  = 32'hFFFFFFFF;
            end
            MODE_ZERO:
            begin
                kp   = 32'd0;
                iti  = 32'd0;
                hts  = 32'd0;
                ilim = 32'd0;
                omin = 32'd0;
                omax = 32'd0;
                stp  = 32'd0;
            end
            MODE_INVERTED:
            begin
                omin = $urandom_range(1, 1 << 24);
                omax = -$urandom_range(0, 1 << 24);
            end
            MODE_FULL:
            begin
                kp   = $urandom;
                iti  = $urandom;
                hts  = $urandom;
                ilim = $urandom;
                omin = $urandom;
                omax = $urandom;
                stp  = $urandom;
            end
            default:
            begin
            end
        endcase
        cfg_write(CFG_GAIN_KP, kp);
        cfg_write(CFG_INV_TI, iti);
        cfg_write(CFG_HALF_TS, hts);
        cfg_write(CFG_INTEGRAL_LIMIT, ilim);
        cfg_write(CFG_OUT_MIN, omin);
        cfg_write(CFG_OUT_MAX, omax);
        cfg_write(CFG_STEP_LIMIT, stp);
        @(negedge clk);
        cfg_we <= 1'b0;
        n_configs++;
    endtask

    task automatic send_item(input logic op, input logic signed [31:0] meas,
                             input logic signed [31:0] tgt, input logic typed,
                             input drive_result_t typed_res);
        int gap;
        drive_result_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {tgt, meas};
        s_tuser <= op;
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_RAMP)
        begin
            ramp_setpoint(tgt);
            n_ramps++;
        end
        else
        begin
            r = regulate_sample(meas);
            expected_drives.push_back(typed ? typed_res : r);
            n_samples++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
    endtask

    // receiver: runs of ready and stall of random length
    initial
    begin
        int hold;
        logic lvl;
        m_tready = 1'b0;
        forever
        begin
            lvl = ($urandom_range(0, 3) != 0);
            hold = lvl ? $urandom_range(1, 30) : $urandom_range(1, 12);
            repeat (hold)
            begin
                @(negedge clk);
                m_tready <= lvl;
            end
        end
    end

    always @(posedge clk)
    begin
        drive_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drives.size() == 0)
            begin
                $error("unexpected item: drive %h limit_status %0d", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                e = expected_drives.pop_front();
                n_results++;
                if (m_tdata !== e.drive)
                begin
                    $error("drive: expected %h, got %h", e.drive, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== e.status)
                begin
                    $error("limit_status: expected %0d, got %0d", e.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        int k;
        int span;
        longint v;
        logic op;
        logic signed [31:0] meas;
        logic signed [31:0] tgt;
        drive_result_t none_res;

        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_GAIN_KP;
        cfg_data = 32'd0;
        rst_n = 1'b0;
        none_res = '{drive: 32'd0, status: STAT_NONE};

        kp_q = longint'(KP_RESET);
        inv_ti_q = longint'(INV_TI_RESET);
        half_ts_q = longint'(HALF_TS_RESET);
        ilimit_q = longint'(ILIMIT_RESET);
        out_min_q = longint'(OUT_MIN_RESET);
        out_max_q = longint'(OUT_MAX_RESET);
        step_q = longint'(STEP_RESET);
        err_prev = 0;
        integ_prev = 0;
        setpoint = 0;

        directed_rows[0]  = '{OP_SAMPLE, 32'sd0, 32'sd0, 1'b1, 32'd0, STAT_MIN};
        directed_rows[1]  = '{OP_SAMPLE, S32_MIN, 32'sd0, 1'b1, OUT_MAX_RESET, STAT_MAX};
        directed_rows[2]  = '{OP_SAMPLE, S32_MAX, 32'sd0, 1'b1, 32'd0, STAT_MIN};
        directed_rows[3]  = '{OP_RAMP, 32'sd0, S32_MAX, 1'b0, 32'd0, STAT_NONE};
        directed_rows[4]  = '{OP_RAMP, 32'sd0, 32'sd16484, 1'b0, 32'd0, STAT_NONE};
        directed_rows[5]  = '{OP_RAMP, 32'sd0, 32'sd32868, 1'b0, 32'd0, STAT_NONE};
        directed_rows[6]  = '{OP_SAMPLE, 32'sd0, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[7]  = '{OP_SAMPLE, -32'sd32768, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[8]  = '{OP_SAMPLE, 32'sd65536, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[9]  = '{OP_SAMPLE, -32'sd6553600, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[10] = '{OP_RAMP, 32'sd0, S32_MIN, 1'b0, 32'd0, STAT_NONE};
        directed_rows[11] = '{OP_SAMPLE, S32_MAX, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[12] = '{OP_SAMPLE, S32_MIN, 32'sd0, 1'b0, 32'd0, STAT_NONE};
        directed_rows[13] = '{OP_RAMP, 32'sd0, S32_MAX, 1'b0, 32'd0, STAT_NONE};
        directed_rows[14] = '{OP_RAMP, S32_MAX, S32_MIN + 32'sd32769, 1'b0, 32'd0, STAT_NONE};
        directed_rows[15] = '{OP_SAMPLE, 32'sd0, S32_MAX, 1'b0, 32'd0, STAT_NONE};

        phase_modes = '{MODE_NOMINAL, MODE_NOMINAL, MODE_MAX, MODE_NOMINAL, MODE_ZERO,
                        MODE_INVERTED, MODE_FULL, MODE_NOMINAL, MODE_INVERTED,
                        MODE_NOMINAL};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
        begin
            send_item(directed_rows[k].op, directed_rows[k].measured,
                      directed_rows[k].target, directed_rows[k].typed,
                      '{drive: directed_rows[k].drive, status: directed_rows[k].status});
        end

        // phase 0 keeps the reset settings
        for (phase = 0; phase < N_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                load_config(phase_modes[phase]);
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                op = ($urandom_range(0, 3) == 0) ? OP_RAMP : OP_SAMPLE;
                meas = $urandom;
                tgt = $urandom;
                if (op == OP_SAMPLE)
                begin
                    case ($urandom_range(0, 9))
                        0:       ;
                        1:       meas = $urandom_range(0, 1) ? S32_MIN : S32_MAX;
                        default:
                        begin
                            span = 1 << $urandom_range(4, 22);
                            v = clip32(setpoint + longint'($urandom_range(0, 2 * span))
                                       - longint'(span));
                            meas = v[31:0];
                        end
                    endcase
                end
                else
                begin
                    case ($urandom_range(0, 7))
                        0:       ;
                        1:
                        begin
                            v = clip32(setpoint - longint'($urandom_range(0, 1 << 24)));
                            tgt = v[31:0];
                        end
                        2:       tgt = $urandom_range(0, 1) ? S32_MIN : S32_MAX;
                        default:
                        begin
                            v = clip32(setpoint + longint'($urandom_range(0, 3)) * step_q
                                       + longint'($urandom_range(0, 255))
                                       - longint'($urandom_range(0, 255)));
                            tgt = v[31:0];
                        end
                    endcase
                end
                send_item(op, meas, tgt, 1'b0, none_res);
            end
        end

        drain();
        repeat (20) @(posedge clk);

        $display("%0d control samples and %0d ramp steps sent, %0d drive items checked",
                 n_samples, n_ramps, n_results);
        $display("register settings covered: reset plus %0d written sets", n_configs);
        if (fail_count == 0 && expected_drives.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
